@@ rtl/xcr_pkg.sv @@
// Shared types and character codes of the XML character reference decoder.
package xcr_pkg;

	// Result queue depth; an item may need room for two results.
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);
	localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

	// Status codes reported on the last result of a value.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD_REF = 2'd1;
	localparam logic [1:0] STATUS_NO_SEMI = 2'd2;

	// Code units that the decoder looks for.
	localparam logic [15:0] CH_AMP   = 16'h0026;
	localparam logic [15:0] CH_SEMI  = 16'h003B;
	localparam logic [15:0] CH_HASH  = 16'h0023;
	localparam logic [15:0] CH_LT    = 16'h003C;
	localparam logic [15:0] CH_GT    = 16'h003E;
	localparam logic [15:0] CH_APOS  = 16'h0027;
	localparam logic [15:0] CH_QUOT  = 16'h0022;
	localparam logic [15:0] CH_LOW_L = 16'h006C;
	localparam logic [15:0] CH_LOW_T = 16'h0074;
	localparam logic [15:0] CH_LOW_G = 16'h0067;
	localparam logic [15:0] CH_LOW_A = 16'h0061;
	localparam logic [15:0] CH_LOW_M = 16'h006D;
	localparam logic [15:0] CH_LOW_P = 16'h0070;
	localparam logic [15:0] CH_LOW_O = 16'h006F;
	localparam logic [15:0] CH_LOW_S = 16'h0073;
	localparam logic [15:0] CH_LOW_Q = 16'h0071;
	localparam logic [15:0] CH_LOW_U = 16'h0075;
	localparam logic [15:0] CH_LOW_X = 16'h0078;
	localparam logic [15:0] CH_UP_X  = 16'h0058;

	// Code point limits.
	localparam logic [20:0] MAX_CP       = 21'h10FFFF;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [20:0] NONCHAR_LO   = 21'h00FDD0;
	localparam logic [20:0] NONCHAR_HI   = 21'h00FDEF;
	localparam logic [15:0] NONCHAR_MASK = 16'hFFFE;
	localparam logic [15:0] SURR_HIGH    = 16'hD800;
	localparam logic [15:0] SURR_LOW     = 16'hDC00;
	localparam logic [9:0]  SURR_MASK    = 10'h3FF;

	// Reference context that reset clears.
	typedef struct packed {
		logic        in_ref;
		logic [2:0]  len;
		logic [20:0] val;
		logic        hex;
		logic        bad;
		logic        ovf;
		logic        err;
	} ref_state_t;

	// First four units of a reference.
	typedef logic [3:0][15:0] name_chars_t;

	// Write of one name unit.
	typedef struct packed {
		logic        we;
		logic [1:0]  idx;
		logic [15:0] data;
	} name_wr_t;

	// One result item.
	typedef struct packed {
		logic [15:0] unit;
		logic        valid;
		logic        last;
		logic [1:0]  status;
	} result_t;

endpackage

@@ rtl/xcr_decode.sv @@
// Combinational decode of one code unit against the reference context.
module xcr_decode
	import xcr_pkg::*;
(
	input  logic        fire,
	input  logic [15:0] code_unit,
	input  logic        has_char,
	input  logic        end_of_value,
	input  ref_state_t  cur,
	input  name_chars_t names,
	output ref_state_t  nxt,
	output name_wr_t    name_wr,
	output result_t     res0,
	output result_t     res1,
	output logic [1:0]  push_n
);

	logic        is_hash;
	logic        named_ok;
	logic [15:0] named_unit;
	logic        nonchar;
	logic        num_bad;
	logic        ref_bad;
	logic        supp;
	logic [19:0] supp_off;
	logic        dig_ok;
	logic [3:0]  dig;
	logic [24:0] acc;
	logic [1:0]  n;
	logic [1:0]  last_status;

	assign is_hash = (names[0] == CH_HASH);

	// Recognise the five predefined entity names.
	always_comb begin
		named_ok   = 1'b0;
		named_unit = CH_LT;
		if (cur.len == 3'd2 && names[0] == CH_LOW_L && names[1] == CH_LOW_T) begin
			named_ok   = 1'b1;
			named_unit = CH_LT;
		end else if (cur.len == 3'd2 && names[0] == CH_LOW_G && names[1] == CH_LOW_T) begin
			named_ok   = 1'b1;
			named_unit = CH_GT;
		end else if (cur.len == 3'd3 && names[0] == CH_LOW_A && names[1] == CH_LOW_M
				&& names[2] == CH_LOW_P) begin
			named_ok   = 1'b1;
			named_unit = CH_AMP;
		end else if (cur.len == 3'd4 && names[0] == CH_LOW_A && names[1] == CH_LOW_P
				&& names[2] == CH_LOW_O && names[3] == CH_LOW_S) begin
			named_ok   = 1'b1;
			named_unit = CH_APOS;
		end else if (cur.len == 3'd4 && names[0] == CH_LOW_Q && names[1] == CH_LOW_U
				&& names[2] == CH_LOW_O && names[3] == CH_LOW_T) begin
			named_ok   = 1'b1;
			named_unit = CH_QUOT;
		end
	end

	// Validity of a numeric reference at the closing semicolon.
	assign nonchar = ((cur.val[15:0] & NONCHAR_MASK) == NONCHAR_MASK)
		|| (cur.val >= NONCHAR_LO && cur.val <= NONCHAR_HI);
	assign num_bad = cur.bad || cur.ovf || (cur.hex && cur.len < 3'd3) || nonchar;
	assign ref_bad = (cur.len < 3'd2) || (is_hash ? num_bad : !named_ok);

	// Surrogate pair split for supplementary code points.
	assign supp     = (cur.val >= SUPP_BASE);
	assign supp_off = 20'(cur.val - SUPP_BASE);

	// Digit value and the accumulated number with the new digit.
	always_comb begin
		dig_ok = 1'b0;
		dig    = code_unit[3:0];
		if (code_unit >= 16'h0030 && code_unit <= 16'h0039) begin
			dig_ok = 1'b1;
		end else if (cur.hex && ((code_unit >= 16'h0061 && code_unit <= 16'h0066)
				|| (code_unit >= 16'h0041 && code_unit <= 16'h0046))) begin
			dig_ok = 1'b1;
			dig    = code_unit[3:0] + 4'd9;
		end
		if (cur.hex) begin
			acc = {cur.val, dig};
		end else begin
			acc = {1'b0, cur.val, 3'b000} + {3'b000, cur.val, 1'b0} + {21'd0, dig};
		end
	end

	// Context update and results of the item.
	always_comb begin
		nxt          = cur;
		name_wr.we   = 1'b0;
		name_wr.idx  = cur.len[1:0];
		name_wr.data = code_unit;
		res0         = '0;
		res1         = '0;
		n            = 2'd0;
		last_status  = STATUS_OK;
		if (has_char && !cur.err) begin
			if (!cur.in_ref) begin
				if (code_unit == CH_AMP) begin
					nxt.in_ref = 1'b1;
					nxt.len    = 3'd0;
					nxt.val    = '0;
					nxt.hex    = 1'b0;
					nxt.bad    = 1'b0;
					nxt.ovf    = 1'b0;
				end else begin
					res0.unit  = code_unit;
					res0.valid = 1'b1;
					n          = 2'd1;
				end
			end else if (code_unit == CH_SEMI) begin
				nxt.in_ref = 1'b0;
				if (ref_bad) begin
					nxt.err = 1'b1;
				end else if (!is_hash) begin
					res0.unit  = named_unit;
					res0.valid = 1'b1;
					n          = 2'd1;
				end else if (supp) begin
					res0.unit  = SURR_HIGH | {6'd0, supp_off[19:10]};
					res0.valid = 1'b1;
					res1.unit  = SURR_LOW | {6'd0, supp_off[9:0] & SURR_MASK};
					res1.valid = 1'b1;
					n          = 2'd2;
				end else begin
					res0.unit  = cur.val[15:0];
					res0.valid = 1'b1;
					n          = 2'd1;
				end
			end else begin
				name_wr.we = !cur.len[2];
				if (cur.len != 3'd0 && is_hash) begin
					if (cur.len == 3'd1 && (code_unit == CH_LOW_X || code_unit == CH_UP_X)) begin
						nxt.hex = 1'b1;
					end else if (!dig_ok) begin
						nxt.bad = 1'b1;
					end else if (!cur.ovf) begin
						if (acc > {4'd0, MAX_CP}) begin
							nxt.ovf = 1'b1;
						end else begin
							nxt.val = acc[20:0];
						end
					end
				end
				if (cur.len != 3'd7) begin
					nxt.len = cur.len + 3'd1;
				end
			end
		end
		// End of the value: report the status on its final result.
		if (end_of_value) begin
			if (nxt.err) begin
				last_status = STATUS_BAD_REF;
			end else if (nxt.in_ref) begin
				last_status = STATUS_NO_SEMI;
			end
			if (n == 2'd2) begin
				res1.last   = 1'b1;
				res1.status = last_status;
			end else begin
				res0.last   = 1'b1;
				res0.status = last_status;
				n           = 2'd1;
			end
			nxt = '0;
		end
		name_wr.we = name_wr.we && fire;
		push_n     = fire ? n : 2'd0;
	end

endmodule

@@ rtl/xcr_out_fifo.sv @@
// Small result queue that takes up to two results per cycle and gives one.
module xcr_out_fifo
	import xcr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  result_t           res0,
	input  result_t           res1,
	input  logic              pop,
	output result_t           head,
	output logic [FifoCw-1:0] count
);

	result_t           mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_q;
	logic [FifoAw-1:0] rd_q;
	logic [FifoCw-1:0] count_q;
	logic [FifoAw-1:0] wr_next;

	assign wr_next = wr_q + FifoAw'(1);
	assign head    = mem_q[rd_q];
	assign count   = count_q;

	// Result storage; the second result goes in the entry after the first.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next] <= res1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FifoAw'(push_n);
			rd_q    <= rd_q + FifoAw'(pop);
			count_q <= count_q + FifoCw'(push_n) - FifoCw'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(FifoCw'(push_n) + count_q) <= FifoCw'(FifoDepth) + FifoCw'(pop))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue read while empty");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == 2'd0) |=> count_q == $past(count_q) - FifoCw'(1))
		else $error("result queue count lost track on a read");

endmodule

@@ rtl/xml_char_reference_decoder.sv @@
// Top level of the XML character reference decoder.
// A result goes into the result queue as its item is accepted and leaves from there.
// Throughput: one item per cycle, but input waits once the queue holds three results;
// the queue gives one result per cycle, so a surrogate pair leaves as two results.
// Reset: arst_n clears the reference context and empties the result queue at once;
// the stored name units have no reset and are only read after they are written.
module xml_char_reference_decoder
	import xcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // code_unit
	input  logic        s_tuser,  // has_char
	input  logic        s_tlast,  // end_of_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_unit
	output logic [2:0]  m_tuser,  // out_valid, status[1:0]
	output logic        m_tlast   // last
);

	ref_state_t        state_q;
	name_chars_t       names_q;
	ref_state_t        state_nxt;
	name_wr_t          name_wr;
	result_t           res0;
	result_t           res1;
	result_t           head;
	logic [1:0]        push_n;
	logic [FifoCw-1:0] count;
	logic              fire;
	logic              pop;

	// Accept while the queue has room for two more results.
	assign s_tready = (count <= FifoCw'(FifoDepth - 2));
	assign fire     = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	xcr_decode u_decode (
		.fire         (fire),
		.code_unit    (s_tdata),
		.has_char     (s_tuser),
		.end_of_value (s_tlast),
		.cur          (state_q),
		.names        (names_q),
		.nxt          (state_nxt),
		.name_wr      (name_wr),
		.res0         (res0),
		.res1         (res1),
		.push_n       (push_n)
	);

	// Reference context.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// First units of the reference name.
	always_ff @(posedge clk) begin
		if (name_wr.we) begin
			names_q[name_wr.idx] <= name_wr.data;
		end
	end

	xcr_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.res0   (res0),
		.res1   (res1),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	// Output channel.
	assign m_tvalid = (count != '0);
	assign m_tdata  = head.unit;
	assign m_tuser  = {head.status, head.valid};
	assign m_tlast  = head.last;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && s_tlast) |=> (!state_q.in_ref && !state_q.err && state_q.len == 3'd0))
		else $error("context not cleared after the end of a value");

	a_err_outside_ref: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.err |-> !state_q.in_ref)
		else $error("error latched while inside a reference");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && state_q.err && !s_tlast) |-> push_n == 2'd0)
		else $error("result produced after an error");

	a_end_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && s_tlast) |-> (push_n != 2'd0 && (push_n == 2'd2 ? res1.last : res0.last)))
		else $error("end item without a final result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the XML character reference decoder: directed and random values.
module tb_top
	import xcr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// One decoded result as the receiver should see it.
	typedef struct packed {
		logic [15:0] unit;
		logic        valid;
		logic        last;
		logic [1:0]  status;
	} decoded_unit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // code_unit
	logic        s_tuser = 1'b0; // has_char
	logic        s_tlast = 1'b0; // end_of_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // out_unit
	logic [2:0]  m_tuser;        // out_valid, status[1:0]
	logic        m_tlast;        // last

	// Results still owed by the decoder, oldest first.
	decoded_unit_t expected_units [$];
	int            mismatches = 0;

	// Idling of both sides, in percent of cycles, and the share of ignored items.
	int unsigned send_gap_pct = 0;
	int unsigned ready_stall_pct = 0;
	int unsigned noise_pct = 0;

	// Code units of the value being assembled.
	logic [15:0] value_text [$];

	// Own copy of the reference context.
	logic        ref_open = 1'b0;
	logic [2:0]  ref_len = '0;
	logic [15:0] ref_name [4] = '{default: '0};
	logic [20:0] ref_value = '0;
	logic        ref_hex = 1'b0;
	logic        ref_bad = 1'b0;
	logic        ref_ovf = 1'b0;
	logic [1:0]  err_status = STATUS_OK;

	xml_char_reference_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver stalls at random.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= ready_stall_pct);
	end

	// True when the stored reference name is exactly the given text.
	function automatic bit name_is(input string txt);
		if (ref_len != 3'(txt.len()))
			return 1'b0;
		for (int i = 0; i < txt.len(); i++)
			if (ref_name[i] != {8'h00, txt[i]})
				return 1'b0;
		return 1'b1;
	endfunction

	// Works out the results of one accepted item and queues them.
	task automatic decode_item(input logic [15:0] cu, input logic has, input logic eov);
		decoded_unit_t res [2];
		int            n;
		logic          ref_ok;
		logic          digit_ok;
		logic [3:0]    d;
		logic [31:0]   v;
		logic [20:0]   cp;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (has && err_status == STATUS_OK) begin
			if (!ref_open) begin
				if (cu == CH_AMP) begin
					ref_open = 1'b1;
					ref_len = '0;
					ref_value = '0;
					ref_hex = 1'b0;
					ref_bad = 1'b0;
					ref_ovf = 1'b0;
				end else begin
					res[0].unit = cu;
					res[0].valid = 1'b1;
					n = 1;
				end
			end else if (cu == CH_SEMI) begin
				// Resolve the reference into one unit or a surrogate pair.
				ref_open = 1'b0;
				ref_ok = 1'b0;
				if (ref_len >= 3'd2 && ref_name[0] != CH_HASH) begin
					ref_ok = 1'b1;
					n = 1;
					if (name_is("lt"))
						res[0].unit = CH_LT;
					else if (name_is("gt"))
						res[0].unit = CH_GT;
					else if (name_is("amp"))
						res[0].unit = CH_AMP;
					else if (name_is("apos"))
						res[0].unit = CH_APOS;
					else if (name_is("quot"))
						res[0].unit = CH_QUOT;
					else
						ref_ok = 1'b0;
				end else if (ref_len >= 3'd2 && !ref_bad && !ref_ovf
						&& !(ref_hex && ref_len < 3'd3)) begin
					cp = ref_value;
					if ((cp[15:0] & NONCHAR_MASK) != NONCHAR_MASK
							&& !(cp >= NONCHAR_LO && cp <= NONCHAR_HI)) begin
						ref_ok = 1'b1;
						if (cp >= SUPP_BASE) begin
							cp = cp - SUPP_BASE;
							res[0].unit = SURR_HIGH | {6'd0, cp[19:10]};
							res[1].unit = SURR_LOW | {6'd0, cp[9:0] & SURR_MASK};
							n = 2;
						end else begin
							res[0].unit = cp[15:0];
							n = 1;
						end
					end
				end
				if (ref_ok) begin
					res[0].valid = 1'b1;
					res[1].valid = (n == 2);
				end else begin
					err_status = STATUS_BAD_REF;
					n = 0;
				end
			end else begin
				// Collect a name unit or a digit of a numeric reference.
				if (ref_len < 3'd4)
					ref_name[ref_len[1:0]] = cu;
				if (ref_len >= 3'd1 && ref_name[0] == CH_HASH) begin
					if (ref_len == 3'd1 && (cu == CH_LOW_X || cu == CH_UP_X)) begin
						ref_hex = 1'b1;
					end else begin
						digit_ok = 1'b1;
						d = cu[3:0];
						if (cu >= "0" && cu <= "9")
							d = cu[3:0];
						else if (ref_hex && ((cu >= "a" && cu <= "f") || (cu >= "A" && cu <= "F")))
							d = cu[3:0] + 4'd9;
						else
							digit_ok = 1'b0;
						if (!digit_ok) begin
							ref_bad = 1'b1;
						end else if (!ref_ovf) begin
							v = ref_hex ? {7'd0, ref_value, d} : 32'(ref_value) * 32'd10 + 32'(d);
							if (v > 32'(MAX_CP))
								ref_ovf = 1'b1;
							else
								ref_value = v[20:0];
						end
					end
				end
				if (ref_len < 3'd7)
					ref_len = ref_len + 3'd1;
			end
		end
		// The end of a value closes the last result, or an empty one, with the status.
		if (eov) begin
			if (ref_open && err_status == STATUS_OK)
				err_status = STATUS_NO_SEMI;
			if (n == 0)
				n = 1;
			res[n-1].last = 1'b1;
			res[n-1].status = err_status;
			ref_open = 1'b0;
			ref_len = '0;
			ref_value = '0;
			ref_hex = 1'b0;
			ref_bad = 1'b0;
			ref_ovf = 1'b0;
			err_status = STATUS_OK;
		end
		for (int i = 0; i < n; i++)
			expected_units = {expected_units, res[i]};
	endtask

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin : check_results
		decoded_unit_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_units.size() == 0) begin
				$error("unexpected result: out_unit %h, out_valid %b, last %b",
					m_tdata, m_tuser[0], m_tlast);
				mismatches++;
			end else begin
				want = expected_units.pop_front();
				if (m_tdata !== want.unit) begin
					$error("out_unit: expected %h, actual %h", want.unit, m_tdata);
					mismatches++;
				end
				if (m_tuser[0] !== want.valid) begin
					$error("out_valid: expected %b, actual %b", want.valid, m_tuser[0]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, actual %b", want.last, m_tlast);
					mismatches++;
				end
				if (m_tuser[2:1] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser[2:1]);
					mismatches++;
				end
			end
		end
	end

	// Offer one item, after a random gap, and predict once it is taken.
	task automatic send_item(input logic [15:0] cu, input logic has, input logic eov);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cu;
		s_tuser  <= has;
		s_tlast  <= eov;
		do
			@(posedge clk);
		while (!s_tready);
		decode_item(cu, has, eov);
	endtask

	// Append one code unit to the value being assembled.
	task automatic append_unit(input logic [15:0] cu);
		value_text = {value_text, cu};
	endtask

	task automatic add_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			append_unit({8'h00, txt[i]});
	endtask

	// Send the assembled value, closed by a separate end marker or on its last unit.
	task automatic send_value(input bit end_marker);
		for (int i = 0; i < value_text.size(); i++) begin
			if ($urandom_range(99) < noise_pct)
				send_item(16'($urandom_range(16'hFFFF)), 1'b0, 1'b0);
			send_item(value_text[i], 1'b1, !end_marker && i == value_text.size() - 1);
		end
		if (end_marker || value_text.size() == 0)
			send_item(16'($urandom_range(16'hFFFF)), 1'b0, 1'b1);
		value_text.delete();
	endtask

	// Hold the sender back until every owed result has arrived.
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Extreme code units, a plain semicolon, an ignored item and an empty value.
	task automatic test_plain_units();
		append_unit(16'h0000);
		append_unit(16'hFFFF);
		append_unit(CH_SEMI);
		send_value(1'b0);
		send_item(16'hFFFF, 1'b0, 1'b0);
		send_value(1'b1);
	endtask

	task automatic test_named_references();
		add_text("&lt;&gt;&amp;&apos;&quot;");
		send_value(1'b1);
	endtask

	// Decimal, hexadecimal in both cases, a surrogate pair and many leading zeros.
	task automatic test_numeric_references();
		add_text("&#65;&#X10FFFD;&#x1f600;&#0000000065;");
		send_value(1'b0);
	endtask

	// Each broken reference in a value of its own; units after the error are dropped.
	task automatic test_invalid_references();
		add_text("&;");
		send_value(1'b0);
		add_text("&#x;");
		send_value(1'b1);
		add_text("&quote;");
		send_value(1'b0);
		add_text("&#xFFFE;");
		send_value(1'b0);
		add_text("&#64976;");
		send_value(1'b0);
		add_text("&#x110000;z");
		send_value(1'b0);
		add_text("&l&;");
		send_value(1'b0);
		add_text("&#1a;");
		send_value(1'b1);
	endtask

	// A value that ends inside a reference, once on a unit and once on a marker.
	task automatic test_missing_semicolon();
		add_text("a&amp");
		send_value(1'b0);
		add_text("&#1");
		send_value(1'b1);
	endtask

	// Mostly well-formed values with random content, some broken or truncated.
	task automatic random_values(input int n_items);
		int          sent;
		int unsigned pick;
		int unsigned cp;
		bit          hex;
		string       digits;
		sent = 0;
		while (sent < n_items) begin
			repeat ($urandom_range(1, 6)) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					append_unit(16'($urandom_range(16'hFFFF)));
				end else if (pick < 40) begin
					append_unit(16'($urandom_range(8'h20, 8'h7E)));
				end else if (pick < 55) begin
					case ($urandom_range(4))
						0: add_text("&lt;");
						1: add_text("&gt;");
						2: add_text("&amp;");
						3: add_text("&apos;");
						default: add_text("&quot;");
					endcase
				end else if (pick < 92) begin
					// Numeric reference over every class of code point.
					case ($urandom_range(6))
						0: cp = $urandom_range(127);
						1: cp = $urandom_range(16'hFFFF);
						2: cp = $urandom_range(32'h10000, 32'h10FFFF);
						3: cp = 32'hFDD0 + $urandom_range(31);
						4: cp = ($urandom_range(16) << 16) | 32'hFFFE | $urandom_range(1);
						5: cp = $urandom_range(32'h110000, 32'hFFFFFFFF);
						default: begin
							case ($urandom_range(3))
								0: cp = 32'h10FFFD;
								1: cp = 32'h10000;
								2: cp = 32'hFFFD;
								default: cp = 32'h110000;
							endcase
						end
					endcase
					hex = $urandom_range(1);
					digits = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
					for (int i = 0; i < digits.len(); i++)
						if (digits[i] >= "a" && $urandom_range(1))
							digits[i] = digits[i] - 8'd32;
					if (hex)
						add_text($urandom_range(1) ? "&#x" : "&#X");
					else
						add_text("&#");
					repeat ($urandom_range(3) == 0 ? $urandom_range(1, 4) : 0) add_text("0");
					add_text(digits);
					add_text(";");
				end else begin
					// Broken reference of one kind or another.
					case ($urandom_range(5))
						0: add_text($urandom_range(1) ? "&;" : "&x;");
						1: add_text($urandom_range(1) ? "&#;" : "&#X;");
						2: begin
							add_text("&");
							repeat ($urandom_range(1, 6))
								append_unit(16'($urandom_range("a", "z")));
							add_text(";");
						end
						3: add_text($urandom_range(1) ? "&a&;" : "&#1&;");
						4: add_text($urandom_range(1) ? "&#1g;" : "&#xg;");
						default: begin
							add_text("&");
							repeat ($urandom_range(1, 6))
								append_unit(16'($urandom_range(16'hFFFF)));
							add_text(";");
						end
					endcase
				end
			end
			// Now and then the value stops inside a reference.
			if ($urandom_range(9) == 0) begin
				add_text("&");
				repeat ($urandom_range(3))
					append_unit(16'($urandom_range(8'h23, 8'h7A)));
			end
			pick = $urandom_range(1);
			sent += value_text.size() + pick;
			send_value(pick[0]);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 18;
		ready_stall_pct = 80;
		test_plain_units();
		test_named_references();
		test_numeric_references();
		test_invalid_references();
		test_missing_semicolon();
		pause_until_drained();

		noise_pct = 4;
		random_values(120);
		pause_until_drained();

		send_gap_pct = 80;
		ready_stall_pct = 18;
		random_values(120);
		pause_until_drained();

		send_gap_pct = 0;
		ready_stall_pct = 0;
		random_values(120);
		pause_until_drained();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
